// ----- hw/rtl/bffa_pkg.sv -----
// ----------------------------------------------------------------------------
// bffa_pkg
// shared constants and word types of the bitmap first-free allocator
// ----------------------------------------------------------------------------
package bffa_pkg;

    localparam int NUM_ENTRIES = 4096;
    localparam int WORD_BITS   = 32;
    localparam int WORD_COUNT  = (NUM_ENTRIES + WORD_BITS - 1) / WORD_BITS;
    localparam int BIT_W       = $clog2(WORD_BITS);
    localparam int ADDR_W      = $clog2(WORD_COUNT);
    localparam int IDX_W       = 12;
    localparam int CNT_W       = 13;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 13;

    typedef enum logic [1:0] {
        REQ_ALLOC = 2'd0,
        REQ_FREE  = 2'd1,
        REQ_QUERY = 2'd2,
        REQ_NONE  = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_FREE  = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENTRY_LIMIT = 1'b0,
        REG_START_INDEX = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        req_type_t         req_type;
        logic [IDX_W-1:0]  entry_index;
    } req_t;

    typedef struct packed {
        status_t           status;
        logic [IDX_W-1:0]  granted_index;
        logic              entry_in_use;
        logic [CNT_W-1:0]  used_total;
    } rsp_t;

    typedef struct packed {
        logic                  rd_en;
        logic [ADDR_W-1:0]     rd_addr;
        logic                  wr_en;
        logic [ADDR_W-1:0]     wr_addr;
        logic [WORD_BITS-1:0]  wr_data;
    } mem_cmd_t;

endpackage

// ----- hw/rtl/bffa_bitmap_store.sv -----
// ----------------------------------------------------------------------------
// bffa_bitmap_store
// bitmap word memory with registered read data, words read as zero until written
// ----------------------------------------------------------------------------
module bffa_bitmap_store (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bffa_pkg::mem_cmd_t             cmd,
    output logic [bffa_pkg::WORD_BITS-1:0] rd_data
);

    logic [bffa_pkg::WORD_BITS-1:0]  mem [bffa_pkg::WORD_COUNT];
    logic [bffa_pkg::WORD_COUNT-1:0] valid_reg;
    logic [bffa_pkg::WORD_BITS-1:0]  rd_word_reg;
    logic                            rd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.wr_addr] <= cmd.wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_word_reg <= mem[cmd.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (cmd.wr_en)
            begin
                valid_reg[cmd.wr_addr] <= 1'b1;
            end
            if (cmd.rd_en)
            begin
                rd_hit_reg <= valid_reg[cmd.rd_addr];
            end
        end
    end

    assign rd_data = rd_hit_reg ? rd_word_reg : '0;

endmodule

// ----- hw/rtl/bffa_first_set.sv -----
// ----------------------------------------------------------------------------
// bffa_first_set
// priority encoder: position of the lowest set bit of a bitmap word
// ----------------------------------------------------------------------------
module bffa_first_set (
    input  logic [bffa_pkg::WORD_BITS-1:0] bits,
    output logic                           found,
    output logic [bffa_pkg::BIT_W-1:0]     pos
);

    always_comb
    begin
        pos = '0;
        for (int i = bffa_pkg::WORD_BITS - 1; i >= 0; i--)
        begin
            if (bits[i])
            begin
                pos = bffa_pkg::BIT_W'(i);
            end
        end
    end

    assign found = |bits;

endmodule

// ----- hw/rtl/bitmap_first_free_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// bitmap_first_free_allocator_unit
// used/free bitmap allocator with first-fit search and exact used count
// ----------------------------------------------------------------------------
// requests arrive on in_valid/in_ready as one word (req_type, entry_index);
// every request gives exactly one response word on out_valid/out_ready
// carrying status, granted_index, entry_in_use and used_total.
// the bitmap lives in a 128 x 32 memory with registered read data; a
// request reads, tests and writes back one bitmap word at a time.
// free, query: read the word, check the entry bit, load the response.
// allocate: reads the bitmap words from the start word up to the first
// one with a free entry in range, at most 128 words; the scan reads
// one word per cycle. out-of-range and reserved-type requests skip the memory.
// one request is in flight at a time; in_ready is high while idle.
// the response sits in an output register; while the receiver stalls, a new
// request may still be accepted and processed, and its response waits until
// the output register is taken.
// reset clears the bitmap at once (words read as zero until first written),
// the used count, and sets entry_limit to 4096 and start_index to 0.
// configuration (cfg_write/cfg_index/cfg_data) must be written only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module bitmap_first_free_allocator_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  bffa_pkg::req_t                    in_word,
    output logic                              out_valid,
    input  logic                              out_ready,
    output bffa_pkg::rsp_t                    out_word,
    input  logic                              cfg_write,
    input  logic [bffa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bffa_pkg::CFG_DATA_W-1:0]   cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_CHECK = 4'b0100,
        S_RESP  = 4'b1000
    } state_t;

    state_t                           state_reg, state_next;
    bffa_pkg::req_t                   req_reg;
    bffa_pkg::rsp_t                   rsp_reg, rsp_next;
    bffa_pkg::rsp_t                   out_word_reg, out_word_next;
    logic                             out_valid_reg, out_valid_next;
    logic [bffa_pkg::ADDR_W-1:0]      scan_addr_reg, scan_addr_next;
    logic [bffa_pkg::CNT_W-1:0]       used_count_reg, used_count_next;
    logic [bffa_pkg::CNT_W-1:0]       entry_limit_reg;
    logic [bffa_pkg::IDX_W-1:0]       start_index_reg;

    bffa_pkg::mem_cmd_t               mem_cmd;
    logic [bffa_pkg::WORD_BITS-1:0]   rd_data;

    logic [bffa_pkg::CNT_W-1:0]       lim;
    logic [bffa_pkg::IDX_W-1:0]       lim_m1;
    logic [bffa_pkg::ADDR_W-1:0]      last_word;
    logic [bffa_pkg::WORD_BITS-1:0]   lo_mask, hi_mask, cand;
    logic                             cand_found;
    logic [bffa_pkg::BIT_W-1:0]       cand_pos;
    logic [bffa_pkg::WORD_BITS-1:0]   chk_bit;
    logic                             accept;
    logic                             out_load;

    bffa_bitmap_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (mem_cmd),
        .rd_data (rd_data)
    );

    bffa_first_set u_first (
        .bits  (cand),
        .found (cand_found),
        .pos   (cand_pos)
    );

    // effective limit and scan window
    assign lim = (entry_limit_reg > bffa_pkg::CNT_W'(bffa_pkg::NUM_ENTRIES))
               ? bffa_pkg::CNT_W'(bffa_pkg::NUM_ENTRIES) : entry_limit_reg;
    assign lim_m1    = bffa_pkg::IDX_W'(lim - bffa_pkg::CNT_W'(1));
    assign last_word = lim_m1[bffa_pkg::IDX_W-1:bffa_pkg::BIT_W];

    assign lo_mask = (scan_addr_reg == start_index_reg[bffa_pkg::IDX_W-1:bffa_pkg::BIT_W])
                   ? ({bffa_pkg::WORD_BITS{1'b1}} << start_index_reg[bffa_pkg::BIT_W-1:0])
                   : {bffa_pkg::WORD_BITS{1'b1}};
    assign hi_mask = (scan_addr_reg == last_word)
                   ? ~(({bffa_pkg::WORD_BITS{1'b1}} << 1) << lim_m1[bffa_pkg::BIT_W-1:0])
                   : {bffa_pkg::WORD_BITS{1'b1}};
    assign cand    = ~rd_data & lo_mask & hi_mask;

    assign chk_bit = {{(bffa_pkg::WORD_BITS-1){1'b0}}, 1'b1}
                     << req_reg.entry_index[bffa_pkg::BIT_W-1:0];

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_load = (state_reg == S_RESP) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next      = state_reg;
        scan_addr_next  = scan_addr_reg;
        used_count_next = used_count_reg;
        rsp_next        = rsp_reg;
        mem_cmd         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rsp_next = '0;
                    unique case (in_word.req_type) inside
                        bffa_pkg::REQ_ALLOC:
                        begin
                            if ({1'b0, start_index_reg} >= lim)
                            begin
                                rsp_next.status = bffa_pkg::ST_FULL;
                                state_next      = S_RESP;
                            end
                            else
                            begin
                                scan_addr_next  =
                                    start_index_reg[bffa_pkg::IDX_W-1:bffa_pkg::BIT_W];
                                mem_cmd.rd_en   = 1'b1;
                                mem_cmd.rd_addr =
                                    start_index_reg[bffa_pkg::IDX_W-1:bffa_pkg::BIT_W];
                                state_next      = S_SCAN;
                            end
                        end
                        bffa_pkg::REQ_FREE, bffa_pkg::REQ_QUERY:
                        begin
                            if ({1'b0, in_word.entry_index} >= lim)
                            begin
                                rsp_next.status = bffa_pkg::ST_RANGE;
                                state_next      = S_RESP;
                            end
                            else
                            begin
                                mem_cmd.rd_en   = 1'b1;
                                mem_cmd.rd_addr =
                                    in_word.entry_index[bffa_pkg::IDX_W-1:bffa_pkg::BIT_W];
                                state_next      = S_CHECK;
                            end
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (cand_found)
                begin
                    mem_cmd.wr_en          = 1'b1;
                    mem_cmd.wr_addr        = scan_addr_reg;
                    mem_cmd.wr_data        = rd_data
                        | ({{(bffa_pkg::WORD_BITS-1){1'b0}}, 1'b1} << cand_pos);
                    used_count_next        = used_count_reg + bffa_pkg::CNT_W'(1);
                    rsp_next.status        = bffa_pkg::ST_OK;
                    rsp_next.granted_index = {scan_addr_reg, cand_pos};
                    state_next             = S_RESP;
                end
                else if (scan_addr_reg == last_word)
                begin
                    rsp_next.status = bffa_pkg::ST_FULL;
                    state_next      = S_RESP;
                end
                else
                begin
                    scan_addr_next  = scan_addr_reg + bffa_pkg::ADDR_W'(1);
                    mem_cmd.rd_en   = 1'b1;
                    mem_cmd.rd_addr = scan_addr_reg + bffa_pkg::ADDR_W'(1);
                end
            end
            S_CHECK:
            begin
                if (req_reg.req_type == bffa_pkg::REQ_QUERY)
                begin
                    rsp_next.entry_in_use = |(rd_data & chk_bit);
                end
                else if ((rd_data & chk_bit) == '0)
                begin
                    rsp_next.status = bffa_pkg::ST_FREE;
                end
                else
                begin
                    mem_cmd.wr_en   = 1'b1;
                    mem_cmd.wr_addr =
                        req_reg.entry_index[bffa_pkg::IDX_W-1:bffa_pkg::BIT_W];
                    mem_cmd.wr_data = rd_data & ~chk_bit;
                    if (used_count_reg != '0)
                    begin
                        used_count_next = used_count_reg - bffa_pkg::CNT_W'(1);
                    end
                end
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next            = 1'b1;
            out_word_next             = rsp_reg;
            out_word_next.used_total  = used_count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            used_count_reg  <= '0;
            out_valid_reg   <= 1'b0;
            entry_limit_reg <= bffa_pkg::CNT_W'(bffa_pkg::NUM_ENTRIES);
            start_index_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            used_count_reg <= used_count_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_write)
            begin
                unique case (bffa_pkg::cfg_reg_t'(cfg_index))
                    bffa_pkg::REG_ENTRY_LIMIT: entry_limit_reg <= cfg_data;
                    bffa_pkg::REG_START_INDEX:
                        start_index_reg <= cfg_data[bffa_pkg::IDX_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= in_word;
        end
        scan_addr_reg <= scan_addr_next;
        rsp_reg       <= rsp_next;
        out_word_reg  <= out_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // count never passes the number of entries
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_count_reg <= bffa_pkg::CNT_W'(bffa_pkg::NUM_ENTRIES))
        else $error("used count above entry total");

    // memory never gets a read and a write in the same cycle
    a_mem_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_cmd.rd_en && mem_cmd.wr_en))
        else $error("bitmap read and write collide");

    // scan stays inside the window
    a_scan_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (scan_addr_reg <= last_word))
        else $error("scan past last word");

    // a grant bumps the count by one
    a_grant_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && cand_found)
        |=> (used_count_reg == $past(used_count_reg) + bffa_pkg::CNT_W'(1)))
        else $error("grant without count increment");

    // a response word leaves only through the response state
    a_resp_path: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_RESP))
        else $error("response word outside response state");

endmodule
